// File: hdl/cia_pkg.sv
// ----------------------------------------------------------------------------
// cia_pkg
// Shared types and codes of the checked integer arithmetic unit.
// ----------------------------------------------------------------------------
package cia_pkg;

    localparam int FIELD_WIDTH = 32;

    typedef enum logic [3:0] {
        MODE_UADD = 4'd0,
        MODE_USUB = 4'd1,
        MODE_UMUL = 4'd2,
        MODE_UDIV = 4'd3,
        MODE_UREM = 4'd4,
        MODE_SADD = 4'd5,
        MODE_SSUB = 4'd6,
        MODE_SMUL = 4'd7,
        MODE_SDIV = 4'd8,
        MODE_SREM = 4'd9,
        MODE_U2S  = 4'd10,
        MODE_S2U  = 4'd11
    } mode_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_RANGE   = 2'd1,
        ERR_DIVZERO = 2'd2
    } err_t;

    typedef struct packed {
        logic [3:0]             mode;
        logic [FIELD_WIDTH-1:0] operand_a;
        logic [FIELD_WIDTH-1:0] operand_b;
    } in_item_t;

    typedef struct packed {
        logic [FIELD_WIDTH-1:0] result_value;
        logic [1:0]             error_code;
    } out_item_t;

endpackage

// File: hdl/cia_cell.sv
// ----------------------------------------------------------------------------
// cia_cell
// One step of the chain: one restoring divide bit and one shift-add
// multiply bit on the magnitudes carried with the transaction.
// ----------------------------------------------------------------------------
module cia_cell #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         vld_in,
    input  logic [W-1:0] ma_in,
    input  logic [W-1:0] mb_in,
    input  logic [W-1:0] quo_in,
    input  logic [W:0]   rem_in,
    input  logic [2*W-1:0] prod_in,
    input  logic [W-1:0] side_in,
    output logic         vld_out,
    output logic [W-1:0] ma_out,
    output logic [W-1:0] mb_out,
    output logic [W-1:0] quo_out,
    output logic [W:0]   rem_out,
    output logic [2*W-1:0] prod_out,
    output logic [W-1:0] side_out
);
    logic [W:0]     rem_sh;
    logic [W:0]     rem_diff;
    logic           fits;
    logic [2*W-1:0] prod_next;

    always_comb begin
        rem_sh    = {rem_in[W-1:0], quo_in[W-1]};
        rem_diff  = rem_sh - {1'b0, mb_in};
        fits      = !rem_diff[W];
        prod_next = {prod_in[2*W-2:0], 1'b0};
        if (ma_in[W-1]) begin
            prod_next = prod_next + {{W{1'b0}}, mb_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_out <= 1'b0;
        end else if (en) begin
            vld_out <= vld_in;
        end
        if (en) begin
            ma_out   <= {ma_in[W-2:0], 1'b0};
            mb_out   <= mb_in;
            quo_out  <= {quo_in[W-2:0], fits};
            rem_out  <= fits ? rem_diff : rem_sh;
            prod_out <= prod_next;
            side_out <= side_in;
        end
    end
endmodule

// File: hdl/checked_integer_alu.sv
// ----------------------------------------------------------------------------
// checked_integer_alu
// Range-checked add, subtract, multiply, divide, remainder and conversion.
// ----------------------------------------------------------------------------
// One transaction enters per cycle while the chain advances. The pipeline is
// an input stage, a chain of DATA_WIDTH cells that each resolve one quotient
// bit and one multiplier bit, and an output register. The chain advances
// whenever the output register is empty or being taken.
module checked_integer_alu #(
    parameter int DATA_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cia_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output cia_pkg::out_item_t m_data
);
    import cia_pkg::*;

    localparam int W = DATA_WIDTH;
    localparam int N = W;

    logic en;

    logic [W-1:0] a, b, sa, sb, ma, mb;
    logic         na, nb;

    logic         v_reg;
    logic [W-1:0] ma_reg, mb_reg, a_reg, b_reg;
    logic [3:0]   mode_reg;

    logic [N:0]     c_vld;
    logic [W-1:0]   c_ma   [N+1];
    logic [W-1:0]   c_mb   [N+1];
    logic [W-1:0]   c_quo  [N+1];
    logic [W:0]     c_rem  [N+1];
    logic [2*W-1:0] c_prod [N+1];
    logic [W-1:0]   c_a    [N+1];
    logic [W-1:0]   c_b    [N+1];
    logic [3:0]     c_mode [N+1];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    function automatic logic [W-1:0] trim(input logic [FIELD_WIDTH-1:0] x);
        logic [63:0] t;
        t = 64'(x);
        return t[W-1:0];
    endfunction

    always_comb begin
        a  = trim(s_data.operand_a);
        b  = trim(s_data.operand_b);
        na = a[W-1];
        nb = b[W-1];
        sa = na ? (~a + 1'b1) : a;
        sb = nb ? (~b + 1'b1) : b;
        ma = (s_data.mode == MODE_SMUL || s_data.mode == MODE_SDIV ||
              s_data.mode == MODE_SREM) ? sa : a;
        mb = (s_data.mode == MODE_SMUL || s_data.mode == MODE_SDIV ||
              s_data.mode == MODE_SREM) ? sb : b;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (en) begin
            v_reg <= s_valid;
        end
        if (en) begin
            ma_reg   <= ma;
            mb_reg   <= mb;
            a_reg    <= a;
            b_reg    <= b;
            mode_reg <= s_data.mode;
        end
    end

    assign c_vld[0]  = v_reg;
    assign c_ma[0]   = ma_reg;
    assign c_mb[0]   = mb_reg;
    assign c_quo[0]  = ma_reg;
    assign c_rem[0]  = '0;
    assign c_prod[0] = '0;
    assign c_a[0]    = a_reg;
    assign c_b[0]    = b_reg;
    assign c_mode[0] = mode_reg;

    for (genvar i = 0; i < N; i++) begin : g_chain
        cia_cell #(.W(W)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .vld_in   (c_vld[i]),
            .ma_in    (c_ma[i]),
            .mb_in    (c_mb[i]),
            .quo_in   (c_quo[i]),
            .rem_in   (c_rem[i]),
            .prod_in  (c_prod[i]),
            .side_in  (c_a[i]),
            .vld_out  (c_vld[i+1]),
            .ma_out   (c_ma[i+1]),
            .mb_out   (c_mb[i+1]),
            .quo_out  (c_quo[i+1]),
            .rem_out  (c_rem[i+1]),
            .prod_out (c_prod[i+1]),
            .side_out (c_a[i+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                c_b[i+1]    <= c_b[i];
                c_mode[i+1] <= c_mode[i];
            end
        end
    end

    // Final checks on the exact results.
    logic [W-1:0]   fa, fb, fq, fr, sum, dif, res;
    logic [W:0]     usum;
    logic [2*W-1:0] fp;
    logic           fna, fnb, neg, err_r, err_z;
    logic [1:0]     err;
    logic [63:0]    res64;

    always_comb begin
        fa    = c_a[N];
        fb    = c_b[N];
        fq    = c_quo[N];
        fr    = c_rem[N][W-1:0];
        fp    = c_prod[N];
        fna   = fa[W-1];
        fnb   = fb[W-1];
        neg   = fna != fnb;
        usum  = {1'b0, fa} + {1'b0, fb};
        sum   = usum[W-1:0];
        dif   = fa - fb;
        res   = '0;
        err_r = 1'b0;
        err_z = 1'b0;
        case (c_mode[N])
            MODE_UADD: begin
                err_r = usum[W];
                res   = sum;
            end
            MODE_USUB: begin
                err_r = fa < fb;
                res   = dif;
            end
            MODE_UMUL: begin
                err_r = fp[2*W-1:W] != '0;
                res   = fp[W-1:0];
            end
            MODE_UDIV: begin
                err_z = fb == '0;
                res   = fq;
            end
            MODE_UREM: begin
                err_z = fb == '0;
                res   = fr;
            end
            MODE_SADD: begin
                err_r = (fna == fnb) && (sum[W-1] != fna);
                res   = sum;
            end
            MODE_SSUB: begin
                err_r = (fna != fnb) && (dif[W-1] != fna);
                res   = dif;
            end
            MODE_SMUL: begin
                if (neg) begin
                    err_r = fp[2*W-1:W] != '0 ||
                            (fp[W-1] && fp[W-2:0] != '0);
                end else begin
                    err_r = fp[2*W-1:W] != '0 || fp[W-1];
                end
                res = neg ? (~fp[W-1:0] + 1'b1) : fp[W-1:0];
            end
            MODE_SDIV: begin
                err_z = fb == '0;
                err_r = !neg && fq[W-1];
                res   = neg ? (~fq + 1'b1) : fq;
            end
            MODE_SREM: begin
                err_z = fb == '0;
                res   = fna ? (~fr + 1'b1) : fr;
            end
            MODE_U2S: begin
                err_r = fna;
                res   = fa;
            end
            MODE_S2U: begin
                err_r = fna;
                res   = fa;
            end
            default: begin
                err_r = 1'b1;
            end
        endcase
        if (err_z) begin
            err = ERR_DIVZERO;
        end else if (err_r) begin
            err = ERR_RANGE;
        end else begin
            err = ERR_OK;
        end
        if (err != ERR_OK) begin
            res = '0;
        end
        res64 = 64'(res);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= c_vld[N];
        end
        if (en) begin
            m_data.result_value <= res64[FIELD_WIDTH-1:0];
            m_data.error_code   <= err;
        end
    end
endmodule

// File: bench/checked_integer_alu_tb.sv
// ----------------------------------------------------------------------------
// checked_integer_alu_tb
// Drives directed and random operations through the checked arithmetic unit
// under varying sender and receiver idling, and checks every result against
// an exact range-checked prediction.
// ----------------------------------------------------------------------------
module checked_integer_alu_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cia_pkg::*;

    localparam int DW        = 32;
    localparam int LATENCY   = DW + 2;
    localparam int MAX_CYCLE = 400000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    in_item_t  pending_ops[$];
    out_item_t expected_results[$];
    int        send_idle_pct;
    int        recv_stall_pct;
    int        error_count = 0;
    int        cycle_count = 0;

    checked_integer_alu #(.DATA_WIDTH(DW)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [DW-1:0] mag_of(logic [DW-1:0] x);
        return x[DW-1] ? -x : x;
    endfunction

    function automatic out_item_t predict_checked(in_item_t op);
        out_item_t       res;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
        logic [DW-1:0]   ma;
        logic [DW-1:0]   mb;
        logic [DW:0]     wide;
        logic [2*DW-1:0] prod;
        logic signed [DW+1:0] sx;
        logic            neg;
        a = op.operand_a;
        b = op.operand_b;
        ma = mag_of(a);
        mb = mag_of(b);
        neg = a[DW-1] ^ b[DW-1];
        res.result_value = '0;
        res.error_code = ERR_OK;
        case (op.mode)
            MODE_UADD: begin
                wide = {1'b0, a} + {1'b0, b};
                if (wide[DW]) res.error_code = ERR_RANGE;
                else res.result_value = wide[DW-1:0];
            end
            MODE_USUB: begin
                if (a < b) res.error_code = ERR_RANGE;
                else res.result_value = a - b;
            end
            MODE_UMUL: begin
                prod = {{DW{1'b0}}, a} * {{DW{1'b0}}, b};
                if (prod[2*DW-1:DW] != 0) res.error_code = ERR_RANGE;
                else res.result_value = prod[DW-1:0];
            end
            MODE_UDIV, MODE_UREM: begin
                if (b == 0) res.error_code = ERR_DIVZERO;
                else res.result_value = (op.mode == MODE_UDIV) ? a / b : a % b;
            end
            MODE_SADD, MODE_SSUB: begin
                if (op.mode == MODE_SADD)
                    sx = $signed({{2{a[DW-1]}}, a}) + $signed({{2{b[DW-1]}}, b});
                else
                    sx = $signed({{2{a[DW-1]}}, a}) - $signed({{2{b[DW-1]}}, b});
                if (sx[DW+1:DW-1] != {3{sx[DW-1]}}) res.error_code = ERR_RANGE;
                else res.result_value = sx[DW-1:0];
            end
            MODE_SMUL: begin
                prod = {{DW{1'b0}}, ma} * {{DW{1'b0}}, mb};
                if (prod > (neg ? (64'd1 << (DW-1)) : ((64'd1 << (DW-1)) - 1)))
                    res.error_code = ERR_RANGE;
                else
                    res.result_value = neg ? -prod[DW-1:0] : prod[DW-1:0];
            end
            MODE_SDIV: begin
                if (b == 0) res.error_code = ERR_DIVZERO;
                else if (!neg && ma / mb > {1'b0, {(DW-1){1'b1}}})
                    res.error_code = ERR_RANGE;
                else res.result_value = neg ? -(ma / mb) : ma / mb;
            end
            MODE_SREM: begin
                if (b == 0) res.error_code = ERR_DIVZERO;
                else res.result_value = a[DW-1] ? -(ma % mb) : ma % mb;
            end
            MODE_U2S, MODE_S2U: begin
                if (a[DW-1]) res.error_code = ERR_RANGE;
                else res.result_value = a;
            end
            default: res.error_code = ERR_RANGE;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(0, 15);
            5: return -$urandom_range(1, 16);
            6: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [3:0] m, logic [31:0] a, logic [31:0] b);
        in_item_t op;
        op.mode = m;
        op.operand_a = a;
        op.operand_b = b;
        pending_ops.push_back(op);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_data <= pending_ops[0];
                expected_results.push_back(predict_checked(pending_ops[0]));
                void'(pending_ops.pop_front());
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", m_data.result_value,
                                    32'd0);
                end else begin
                    if (m_data.result_value !== expected_results[0].result_value)
                        report_mismatch("result_value", m_data.result_value,
                                        expected_results[0].result_value);
                    if (m_data.error_code !== expected_results[0].error_code)
                        report_mismatch("error_code", 32'(m_data.error_code),
                                        32'(expected_results[0].error_code));
                    void'(expected_results.pop_front());
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic run_phase(int idle_pct, int stall_pct, int count);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            add_op(4'($urandom_range(0, 15)), pick_operand(), pick_operand());
        while (pending_ops.size() != 0 || s_valid) @(posedge aclk);
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        add_op(MODE_UADD, 32'hFFFF_FFFF, 32'h1);
        add_op(MODE_UADD, 32'hFFFF_FFFE, 32'h1);
        add_op(MODE_USUB, 32'h0, 32'h1);
        add_op(MODE_USUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(MODE_UMUL, 32'h0001_0000, 32'h0001_0000);
        add_op(MODE_UMUL, 32'hFFFF_FFFF, 32'h1);
        add_op(MODE_UDIV, 32'hFFFF_FFFF, 32'h0);
        add_op(MODE_UDIV, 32'hFFFF_FFFF, 32'h7);
        add_op(MODE_UREM, 32'hFFFF_FFFF, 32'h0);
        add_op(MODE_UREM, 32'hFFFF_FFFF, 32'h10);
        add_op(MODE_SADD, 32'h7FFF_FFFF, 32'h1);
        add_op(MODE_SADD, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(MODE_SSUB, 32'h8000_0000, 32'h1);
        add_op(MODE_SSUB, 32'h0, 32'h8000_0000);
        add_op(MODE_SMUL, 32'h8000_0000, 32'h1);
        add_op(MODE_SMUL, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(MODE_SDIV, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(MODE_SDIV, 32'hFFFF_FFF9, 32'h2);
        add_op(MODE_SDIV, 32'h5, 32'h0);
        add_op(MODE_SREM, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(MODE_SREM, 32'hFFFF_FFF9, 32'h2);
        add_op(MODE_U2S, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(MODE_S2U, 32'h7FFF_FFFF, 32'h0);
        add_op(4'd12, 32'h1, 32'h1);
        add_op(4'd15, 32'h0, 32'h0);
        while (pending_ops.size() != 0 || s_valid) @(posedge aclk);

        run_phase(0, 0, 250);
        run_phase(76, 0, 250);
        run_phase(0, 76, 250);
        run_phase(15, 15, 250);

        while (expected_results.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
